// File: design/vfve_pkg.sv
// vfve_pkg: shared types, face codes, light levels and the microcode program
// for the voxel face vertex emitter. No dependencies.
`default_nettype none

package vfve_pkg;

  localparam int unsigned FACE_COUNT     = 6;
  localparam int unsigned VERTS_PER_FACE = 6;
  localparam int unsigned MICRO_STEPS    = FACE_COUNT * VERTS_PER_FACE;
  localparam int unsigned PC_W           = $clog2(MICRO_STEPS + 1);
  localparam logic [PC_W-1:0] END_STEP   = PC_W'(MICRO_STEPS);

  localparam logic [5:0] ALL_SOLID  = 6'h3F;
  localparam logic [5:0] ABOVE_TOP  = 6'h3E;
  localparam logic [7:0] EMPTY_ID   = 8'd0;

  typedef enum logic [2:0] {
    FACE_TOP    = 3'd0,
    FACE_BOTTOM = 3'd1,
    FACE_RIGHT  = 3'd2,
    FACE_LEFT   = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_t;

  // corner code: {add one to v, add one to u, z high, y high, x high}
  typedef logic [4:0] corner_t;

  // one microcode word
  typedef struct packed {
    logic            skip_if_solid;  // first step of a face: jump if neighbour solid
    logic            face_end;       // last vertex of the face
    face_t           face;
    logic [PC_W-1:0] target;         // jump target, END_STEP halts
    corner_t         corner;
  } ctrl_word_t;

  // step command from sequencer to datapath
  typedef struct packed {
    logic    emit;
    logic    last;
    face_t   face;
    corner_t corner;
  } step_t;

  function automatic ctrl_word_t uop(face_t f, logic first, logic fend, corner_t c);
    ctrl_word_t w;
    w.skip_if_solid = first;
    w.face_end      = fend;
    w.face          = f;
    w.target        = PC_W'((int'(f) + 1) * VERTS_PER_FACE);
    w.corner        = c;
    return w;
  endfunction

  localparam ctrl_word_t MICROCODE [MICRO_STEPS] = '{
    uop(FACE_TOP,    1'b1, 1'b0, 5'b01010), uop(FACE_TOP,    1'b0, 1'b0, 5'b11110),
    uop(FACE_TOP,    1'b0, 1'b0, 5'b10111), uop(FACE_TOP,    1'b0, 1'b0, 5'b01010),
    uop(FACE_TOP,    1'b0, 1'b0, 5'b10111), uop(FACE_TOP,    1'b0, 1'b1, 5'b00011),
    uop(FACE_BOTTOM, 1'b1, 1'b0, 5'b00000), uop(FACE_BOTTOM, 1'b0, 1'b0, 5'b11101),
    uop(FACE_BOTTOM, 1'b0, 1'b0, 5'b10100), uop(FACE_BOTTOM, 1'b0, 1'b0, 5'b00000),
    uop(FACE_BOTTOM, 1'b0, 1'b0, 5'b01001), uop(FACE_BOTTOM, 1'b0, 1'b1, 5'b11101),
    uop(FACE_RIGHT,  1'b1, 1'b0, 5'b01001), uop(FACE_RIGHT,  1'b0, 1'b0, 5'b11011),
    uop(FACE_RIGHT,  1'b0, 1'b0, 5'b10111), uop(FACE_RIGHT,  1'b0, 1'b0, 5'b01001),
    uop(FACE_RIGHT,  1'b0, 1'b0, 5'b10111), uop(FACE_RIGHT,  1'b0, 1'b1, 5'b00101),
    uop(FACE_LEFT,   1'b1, 1'b0, 5'b00000), uop(FACE_LEFT,   1'b0, 1'b0, 5'b11110),
    uop(FACE_LEFT,   1'b0, 1'b0, 5'b10010), uop(FACE_LEFT,   1'b0, 1'b0, 5'b00000),
    uop(FACE_LEFT,   1'b0, 1'b0, 5'b01100), uop(FACE_LEFT,   1'b0, 1'b1, 5'b11110),
    uop(FACE_FRONT,  1'b1, 1'b0, 5'b00100), uop(FACE_FRONT,  1'b0, 1'b0, 5'b11111),
    uop(FACE_FRONT,  1'b0, 1'b0, 5'b10110), uop(FACE_FRONT,  1'b0, 1'b0, 5'b00100),
    uop(FACE_FRONT,  1'b0, 1'b0, 5'b01101), uop(FACE_FRONT,  1'b0, 1'b1, 5'b11111),
    uop(FACE_BACK,   1'b1, 1'b0, 5'b01000), uop(FACE_BACK,   1'b0, 1'b0, 5'b11010),
    uop(FACE_BACK,   1'b0, 1'b0, 5'b10011), uop(FACE_BACK,   1'b0, 1'b0, 5'b01000),
    uop(FACE_BACK,   1'b0, 1'b0, 5'b10011), uop(FACE_BACK,   1'b0, 1'b1, 5'b00001)
  };

  // face light in 1/256 units
  function automatic logic [8:0] face_light(face_t f);
    logic [8:0] l;
    unique case (f)
      FACE_TOP:    l = 9'd256;
      FACE_BOTTOM: l = 9'd192;
      FACE_RIGHT:  l = 9'd243;
      FACE_LEFT:   l = 9'd218;
      FACE_FRONT:  l = 9'd230;
      FACE_BACK:   l = 9'd205;
      default:     l = 9'd0;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// File: design/vfve_if.sv
// vfve_if: valid/ready channel interfaces for voxel input words and
// vertex output words. No dependencies.
`default_nettype none

interface vfve_voxel_if;
  logic       valid;
  logic       ready;
  logic [7:0] block_id;
  logic [3:0] voxel_x;
  logic [3:0] voxel_y;
  logic [3:0] voxel_z;
  logic [5:0] neighbour_solid;

  modport source (output valid, block_id, voxel_x, voxel_y, voxel_z, neighbour_solid,
                  input ready);
  modport sink   (input valid, block_id, voxel_x, voxel_y, voxel_z, neighbour_solid,
                  output ready);
endinterface

interface vfve_vertex_if;
  logic              valid;
  logic              ready;
  logic signed [5:0] pos_x;
  logic signed [5:0] pos_y;
  logic signed [5:0] pos_z;
  logic        [4:0] tex_u;
  logic        [4:0] tex_v;
  logic        [8:0] light_level;
  logic        [2:0] face_index;
  logic              last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, light_level,
                  face_index, last_vertex, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, light_level,
                  face_index, last_vertex, output ready);
endinterface

`default_nettype wire

// File: design/vfve_sequencer.sv
// vfve_sequencer: step counter over the microcode program with the
// skip-solid-face jump. Depends on vfve_pkg.
`default_nettype none

module vfve_sequencer
  import vfve_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [5:0] solid,
  input  wire logic       can_emit,
  output step_t           step,
  output logic            busy
);

  logic            busy_next;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_word_t      cw;
  logic            face_solid;
  logic            later_open;

  // control word fetch
  assign cw         = MICROCODE[pc[PC_W-1:0]];
  assign face_solid = solid[cw.face];
  assign later_open = |(~solid & 6'(ABOVE_TOP << cw.face));

  // sequencing and step decode
  always_comb begin
    busy_next   = busy;
    pc_next     = pc;
    step.emit   = 1'b0;
    step.last   = 1'b0;
    step.face   = cw.face;
    step.corner = cw.corner;
    if (busy) begin
      if (cw.skip_if_solid && face_solid) begin
        if (cw.target == END_STEP) begin
          busy_next = 1'b0;
        end else begin
          pc_next = cw.target;
        end
      end else if (can_emit) begin
        step.emit = 1'b1;
        step.last = cw.face_end && !later_open;
        if (step.last) begin
          busy_next = 1'b0;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
    end else if (start) begin
      busy_next = 1'b1;
      pc_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else begin
      busy <= busy_next;
      pc   <= pc_next;
    end
  end

endmodule

`default_nettype wire

// File: design/vfve_datapath.sv
// vfve_datapath: voxel holding register, vertex arithmetic and the output
// word register. Depends on vfve_pkg and vfve_if.
`default_nettype none

module vfve_datapath
  import vfve_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic [7:0] in_block_id,
  input  wire logic [3:0] in_voxel_x,
  input  wire logic [3:0] in_voxel_y,
  input  wire logic [3:0] in_voxel_z,
  input  wire logic [5:0] in_solid,
  input  step_t           step,
  output logic [5:0]      solid,
  output logic            can_emit,
  vfve_vertex_if.source   vertex
);

  logic [7:0] block_id;
  logic [3:0] vx;
  logic [3:0] vy;
  logic [3:0] vz;

  // 2*c + 1 on the high side, 2*c - 1 otherwise
  function automatic logic [5:0] half_unit(logic [3:0] c, logic high);
    logic [5:0] base;
    base = {1'b0, c, 1'b0};
    return high ? (base | 6'd1) : (base - 6'd1);
  endfunction

  // voxel capture
  always_ff @(posedge clk) begin
    if (load) begin
      block_id <= in_block_id;
      vx       <= in_voxel_x;
      vy       <= in_voxel_y;
      vz       <= in_voxel_z;
      solid    <= in_solid;
    end
  end

  assign can_emit = !vertex.valid || vertex.ready;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex.valid <= 1'b0;
    end else if (step.emit) begin
      vertex.valid <= 1'b1;
    end else if (vertex.ready) begin
      vertex.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.emit) begin
      vertex.pos_x       <= half_unit(vx, step.corner[0]);
      vertex.pos_y       <= half_unit(vy, step.corner[1]);
      vertex.pos_z       <= half_unit(vz, step.corner[2]);
      vertex.tex_u       <= {1'b0, block_id[3:0]} + {4'd0, step.corner[3]};
      vertex.tex_v       <= {1'b0, ~block_id[7:4]} + {4'd0, step.corner[4]};
      vertex.light_level <= face_light(step.face);
      vertex.face_index  <= step.face;
      vertex.last_vertex <= step.last;
    end
  end

endmodule

`default_nettype wire

// File: design/voxel_face_vertex_emitter_unit.sv
// voxel_face_vertex_emitter_unit: top level, joins the microcode sequencer
// and the vertex datapath. Depends on vfve_pkg, vfve_if and both submodules.
`default_nettype none

// Takes one voxel word and emits six vertex words for each face whose
// neighbour is not solid, faces in the order top, bottom, right, left, front,
// back, with last_vertex set on the final one. An empty voxel (block id 0) or
// a fully enclosed one emits nothing and does not start the sequencer.
// Otherwise a short microcode program of 36 vertex steps is walked: each
// vertex step emits one vertex when the output register can take it, and each
// solid face met before the last open face is passed over by a jump. The input
// is held (ready low) until the last vertex is emitted. The next voxel is taken
// in the cycle after the last vertex enters the output register, while that
// vertex still waits to be taken.

module voxel_face_vertex_emitter_unit
  import vfve_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  vfve_voxel_if.sink    voxel,
  vfve_vertex_if.source vertex
);

  logic       busy;
  logic       accept;
  logic       start;
  logic       can_emit;
  logic [5:0] solid;
  step_t      step;

  assign voxel.ready = !busy;
  assign accept      = voxel.valid && voxel.ready;
  assign start       = accept && (voxel.block_id != EMPTY_ID)
                       && (voxel.neighbour_solid != ALL_SOLID);

  vfve_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .solid    (solid),
    .can_emit (can_emit),
    .step     (step),
    .busy     (busy)
  );

  vfve_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .in_block_id (voxel.block_id),
    .in_voxel_x  (voxel.voxel_x),
    .in_voxel_y  (voxel.voxel_y),
    .in_voxel_z  (voxel.voxel_z),
    .in_solid    (voxel.neighbour_solid),
    .step        (step),
    .solid       (solid),
    .can_emit    (can_emit),
    .vertex      (vertex)
  );

endmodule

`default_nettype wire

// File: dv/tb_voxel_face_vertex_emitter_unit.sv
// tb_voxel_face_vertex_emitter_unit: drives voxel words into the face vertex
// emitter and checks every vertex word against a local face-culling mesher.
// Depends on vfve_pkg, vfve_if and the voxel_face_vertex_emitter_unit rtl.

module tb_voxel_face_vertex_emitter_unit
  import vfve_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_COUNT    = 108;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 40;

  // one voxel word of stimulus; silent marks rows known to emit nothing
  typedef struct packed {
    logic [7:0] id;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] z;
    logic [5:0] solid;
    logic       silent;
  } voxel_row_t;

  typedef struct packed {
    logic signed [5:0] pos_x;
    logic signed [5:0] pos_y;
    logic signed [5:0] pos_z;
    logic [4:0]        tex_u;
    logic [4:0]        tex_v;
    logic [8:0]        light;
    face_t             face;
    logic              last;
  } vertex_word_t;

  // corner codes {v+1, u+1, z high, y high, x high}, six per face
  localparam logic [0:35][4:0] CORNER_CODES = '{
    5'b01010, 5'b11110, 5'b10111, 5'b01010, 5'b10111, 5'b00011,
    5'b00000, 5'b11101, 5'b10100, 5'b00000, 5'b01001, 5'b11101,
    5'b01001, 5'b11011, 5'b10111, 5'b01001, 5'b10111, 5'b00101,
    5'b00000, 5'b11110, 5'b10010, 5'b00000, 5'b01100, 5'b11110,
    5'b00100, 5'b11111, 5'b10110, 5'b00100, 5'b01101, 5'b11111,
    5'b01000, 5'b11010, 5'b10011, 5'b01000, 5'b10011, 5'b00001
  };

  localparam logic [0:5][8:0] FACE_LIGHT_LUT = '{
    9'd256, 9'd192, 9'd243, 9'd218, 9'd230, 9'd205
  };

  // directed voxels: empty and enclosed cases, extremes, each face alone
  localparam int DIRECTED_COUNT = 22;
  localparam voxel_row_t [0:DIRECTED_COUNT-1] DIRECTED_ROWS = '{
    '{EMPTY_ID, 4'd15, 4'd15, 4'd15, 6'h00,     1'b1},
    '{EMPTY_ID, 4'd0,  4'd0,  4'd0,  ALL_SOLID, 1'b1},
    '{8'd37,    4'd7,  4'd8,  4'd9,  ALL_SOLID, 1'b1},
    '{8'd255,   4'd0,  4'd0,  4'd0,  ALL_SOLID, 1'b1},
    '{8'd1,     4'd0,  4'd0,  4'd0,  6'h00,     1'b0},
    '{8'd255,   4'd15, 4'd15, 4'd15, 6'h00,     1'b0},
    '{8'd240,   4'd0,  4'd15, 4'd0,  6'h00,     1'b0},
    '{8'd15,    4'd15, 4'd0,  4'd15, 6'h00,     1'b0},
    '{8'd16,    4'd3,  4'd12, 4'd6,  ABOVE_TOP, 1'b0},
    '{8'd2,     4'd12, 4'd3,  4'd9,  6'h3D,     1'b0},
    '{8'd100,   4'd15, 4'd4,  4'd0,  6'h3B,     1'b0},
    '{8'd200,   4'd0,  4'd9,  4'd15, 6'h37,     1'b0},
    '{8'd77,    4'd8,  4'd0,  4'd1,  6'h2F,     1'b0},
    '{8'd128,   4'd1,  4'd2,  4'd14, 6'h1F,     1'b0},
    '{8'd9,     4'd5,  4'd5,  4'd5,  6'h01,     1'b0},
    '{8'd18,    4'd6,  4'd7,  4'd8,  6'h02,     1'b0},
    '{8'd33,    4'd9,  4'd10, 4'd11, 6'h04,     1'b0},
    '{8'd64,    4'd11, 4'd13, 4'd2,  6'h08,     1'b0},
    '{8'd170,   4'd4,  4'd1,  4'd13, 6'h10,     1'b0},
    '{8'd85,    4'd10, 4'd14, 4'd3,  6'h20,     1'b0},
    '{8'd51,    4'd2,  4'd6,  4'd10, 6'h15,     1'b0},
    '{8'd204,   4'd13, 4'd11, 4'd7,  6'h2A,     1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  vfve_voxel_if  voxel_ch ();
  vfve_vertex_if vertex_ch ();

  voxel_face_vertex_emitter_unit uut (
    .clk    (clk),
    .rst    (rst),
    .voxel  (voxel_ch),
    .vertex (vertex_ch)
  );

  vertex_word_t pending_vertices [$];
  int           mismatch_count = 0;
  int           vertex_count   = 0;
  int           cycle_count    = 0;
  int           calm_left      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  // face-culling mesher: six vertices per open face, last flag on the final one
  function automatic void queue_mesh_vertices(voxel_row_t v);
    int           last_face;
    int           f;
    int           k;
    logic [4:0]   c;
    vertex_word_t w;
    last_face = -1;
    if (v.id == EMPTY_ID) return;
    for (f = 0; f < 6; f++) if (!v.solid[f]) last_face = f;
    for (f = 0; f < 6; f++) begin
      if (v.solid[f]) continue;
      for (k = 0; k < 6; k++) begin
        c = CORNER_CODES[f * 6 + k];
        w.pos_x = 6'(2 * int'(v.x) + 2 * int'(c[0]) - 1);
        w.pos_y = 6'(2 * int'(v.y) + 2 * int'(c[1]) - 1);
        w.pos_z = 6'(2 * int'(v.z) + 2 * int'(c[2]) - 1);
        w.tex_u = 5'(int'(v.id[3:0]) + int'(c[3]));
        w.tex_v = 5'(15 - int'(v.id[7:4]) + int'(c[4]));
        w.light = FACE_LIGHT_LUT[f];
        w.face  = face_t'(f);
        w.last  = (f == last_face) && (k == 5);
        pending_vertices.push_back(w);
      end
    end
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t vertex %0d %s: got %0d want %0d", $realtime, vertex_count, what, got,
             want);
    mismatch_count++;
  endtask

  // present one voxel word after a random gap and hold it until taken
  task automatic send_voxel(voxel_row_t v);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 5) calm_left = $urandom_range(10, 25);
      gap = idle_len();
    end
    if (gap > 0) begin
      voxel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    voxel_ch.valid           <= 1'b1;
    voxel_ch.block_id        <= v.id;
    voxel_ch.voxel_x         <= v.x;
    voxel_ch.voxel_y         <= v.y;
    voxel_ch.voxel_z         <= v.z;
    voxel_ch.neighbour_solid <= v.solid;
    @(posedge clk);
    while (!voxel_ch.ready) @(posedge clk);
    if (!v.silent) queue_mesh_vertices(v);
  endtask

  // random voxel: some empty or enclosed, some with one open face
  function automatic voxel_row_t random_voxel();
    voxel_row_t v;
    int         r;
    v.silent = 1'b0;
    v.x      = 4'($urandom_range(0, 15));
    v.y      = 4'($urandom_range(0, 15));
    v.z      = 4'($urandom_range(0, 15));
    v.id     = ($urandom_range(0, 99) < 8) ? EMPTY_ID : 8'($urandom_range(1, 255));
    r = $urandom_range(0, 99);
    if (r < 8) v.solid = ALL_SOLID;
    else if (r < 20) v.solid = ALL_SOLID & ~(6'd1 << $urandom_range(0, 5));
    else v.solid = 6'($urandom);
    return v;
  endfunction

  // stimulus
  initial begin
    int         i;
    voxel_row_t v;
    rst                      <= 1'b1;
    voxel_ch.valid           <= 1'b0;
    voxel_ch.block_id        <= '0;
    voxel_ch.voxel_x         <= '0;
    voxel_ch.voxel_y         <= '0;
    voxel_ch.voxel_z         <= '0;
    voxel_ch.neighbour_solid <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < DIRECTED_COUNT; i++) send_voxel(DIRECTED_ROWS[i]);
    for (i = 0; i < RANDOM_COUNT; i++) begin
      v = random_voxel();
      send_voxel(v);
    end
    voxel_ch.valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // output back-pressure: bursts of ready, random stalls, long open stretches
  initial begin
    int burst;
    int stall;
    vertex_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 99) < 6) ? $urandom_range(80, 250) : $urandom_range(1, 8);
      vertex_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = idle_len();
      if (stall > 0) begin
        vertex_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // compare each taken vertex word with the oldest expected one
  always @(posedge clk) begin : vertex_check
    vertex_word_t want;
    if (!rst && vertex_ch.valid && vertex_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        flag_mismatch("unexpected word, face", int'(vertex_ch.face_index), -1);
      end else begin
        want = pending_vertices.pop_front();
        if (vertex_ch.pos_x !== want.pos_x)
          flag_mismatch("pos_x", int'(vertex_ch.pos_x), int'(want.pos_x));
        if (vertex_ch.pos_y !== want.pos_y)
          flag_mismatch("pos_y", int'(vertex_ch.pos_y), int'(want.pos_y));
        if (vertex_ch.pos_z !== want.pos_z)
          flag_mismatch("pos_z", int'(vertex_ch.pos_z), int'(want.pos_z));
        if (vertex_ch.tex_u !== want.tex_u)
          flag_mismatch("tex_u", int'(vertex_ch.tex_u), int'(want.tex_u));
        if (vertex_ch.tex_v !== want.tex_v)
          flag_mismatch("tex_v", int'(vertex_ch.tex_v), int'(want.tex_v));
        if (vertex_ch.light_level !== want.light)
          flag_mismatch("light_level", int'(vertex_ch.light_level), int'(want.light));
        if (vertex_ch.face_index !== want.face)
          flag_mismatch("face_index", int'(vertex_ch.face_index), int'(want.face));
        if (vertex_ch.last_vertex !== want.last)
          flag_mismatch("last_vertex", int'(vertex_ch.last_vertex), int'(want.last));
      end
      vertex_count++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
